// File: rtl/core/matrix_multiply_4x4_core_defines.svh
// Assertion macros for the 4x4 matrix multiply core.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef MATRIX_MULTIPLY_4X4_CORE_DEFINES_SVH
`define MATRIX_MULTIPLY_4X4_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define MM4_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MM4_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MM4_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define MM4_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: rtl/core/mm4_pkg.sv
// Shared types for the 4x4 matrix multiply core: request structs and
// controller/datapath command and status bundles. No dependencies.
package mm4_pkg;

    localparam int DIM    = 4;
    localparam int ELEM_W = 32;
    localparam int IDX_W  = 2;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIM - 1);

    typedef struct packed {
        logic [IDX_W-1:0]         row_index;
        logic signed [ELEM_W-1:0] a_elem0;
        logic signed [ELEM_W-1:0] a_elem1;
        logic signed [ELEM_W-1:0] a_elem2;
        logic signed [ELEM_W-1:0] a_elem3;
        logic signed [ELEM_W-1:0] b_elem0;
        logic signed [ELEM_W-1:0] b_elem1;
        logic signed [ELEM_W-1:0] b_elem2;
        logic signed [ELEM_W-1:0] b_elem3;
    } load_req_t;

    typedef struct packed {
        logic [IDX_W-1:0]         out_row;
        logic signed [ELEM_W-1:0] prod_elem0;
        logic signed [ELEM_W-1:0] prod_elem1;
        logic signed [ELEM_W-1:0] prod_elem2;
        logic signed [ELEM_W-1:0] prod_elem3;
        logic                     last_row;
    } result_req_t;

    // controller -> datapath
    typedef struct packed {
        logic             store_wr;  // write incoming row into both stores
        logic             issue;     // launch one multiply step on all lanes
        logic [IDX_W-1:0] row;       // result row i
        logic [IDX_W-1:0] step;      // inner index k
        logic             first;     // k == 0, restart accumulators
        logic             last;      // k == 3
        logic             load_out;  // move finished row into output register
    } mm4_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic acc_done;  // accumulators hold a finished row
    } mm4_status_t;

endpackage

// File: rtl/core/matrix_multiply_4x4_core.sv
// Top level of the 4x4 matrix multiply core (C = A * B, signed fixed point).
// Depends on mm4_pkg, mm4_ctrl, mm4_datapath and the core defines header.
// Usage:
//  - Load channel (load_valid/load_ready/load_req): each request writes row
//    row_index of both A and B. Rows 0..2 are stored while load_ready stays high.
//  - A request for row 3 writes that row, then computes all of C. The block
//    drops load_ready while computing and emits four result requests, rows
//    0..3 in order, last_row set on row 3.
//  - Per result row: the four multiply lanes take one k per cycle (one
//    multiplier per column), then the product register and accumulator
//    settle and the finished row moves into the result register. Further
//    rows follow while the receiver keeps result_ready high.
//  - Sums are exact, shifted right by FRAC_BITS (floor) and saturated to a
//    signed WORD_BITS value, sign-extended onto the 32-bit fields.
//  - Receiver stall: the result register holds its request; the next row
//    waits finished in the accumulators until the register frees up.
//    Load requests are taken again as soon as the last row is registered.
//  - Reset: stores read as zero, no result pending, ready to load.
//    Rows not reloaded keep their previous contents across products.
`include "matrix_multiply_4x4_core_defines.svh"

module matrix_multiply_4x4_core #(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load_valid,
    output logic                 load_ready,
    input  mm4_pkg::load_req_t   load_req,
    output logic                 result_valid,
    input  logic                 result_ready,
    output mm4_pkg::result_req_t result_req
);
    import mm4_pkg::*;

    mm4_cmd_t    cmd;
    mm4_status_t stat;

    // sequencing: handshake, row/step counters, result valid
    mm4_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .load_valid   (load_valid),
        .load_ready   (load_ready),
        .load_row     (load_req.row_index),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    // stores, MAC lanes, saturation, result register
    mm4_datapath #(
        .FRAC_BITS (FRAC_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .load_req   (load_req),
        .stat       (stat),
        .result_req (result_req)
    );

    // a new row must not start while the previous sum is still unclaimed
    `MM4_ASSERT_NOW(a_issue_acc_clear, clk, rst_n, cmd.issue, !stat.acc_done, "issue with stale accumulator")

    // loading the last result row returns the block to accepting loads
    `MM4_ASSERT_NEXT(a_last_row_idle, clk, rst_n, cmd.load_out && (cmd.row == LAST_IDX), load_ready, "not idle after last row")

    // a taken result without a refill leaves the output empty
    `MM4_ASSERT_NEXT(a_result_drains, clk, rst_n, result_valid && result_ready && !cmd.load_out, !result_valid, "result repeated")

endmodule

// File: rtl/core/mm4_datapath.sv
// Datapath of the 4x4 matrix multiply core: row stores, four MAC lanes,
// shift/saturate and the result register. Depends on mm4_pkg.
module mm4_datapath #(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mm4_pkg::mm4_cmd_t    cmd,
    input  mm4_pkg::load_req_t   load_req,
    output mm4_pkg::mm4_status_t stat,
    output mm4_pkg::result_req_t result_req
);
    import mm4_pkg::*;

    localparam int PROD_W = 2 * WORD_BITS;
    localparam int ACC_W  = PROD_W + 2;
    localparam logic signed [ACC_W-1:0] SAT_MAX =
        (ACC_W'(1) <<< (WORD_BITS - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

    typedef logic signed [WORD_BITS-1:0] word_t;

    word_t a_store_reg [DIM][DIM];
    word_t b_store_reg [DIM][DIM];
    logic [DIM-1:0] row_valid_reg;

    word_t in_a [DIM];
    word_t in_b [DIM];

    word_t a_sel;
    word_t b_sel [DIM];

    logic signed [PROD_W-1:0] prod_reg [DIM];
    logic signed [ACC_W-1:0]  acc_reg  [DIM];
    logic signed [ACC_W-1:0]  acc_next [DIM];
    logic signed [ELEM_W-1:0] sat_elem [DIM];

    logic p_valid_reg, p_first_reg, p_last_reg;
    logic acc_done_reg;

    result_req_t out_reg;

    assign in_a[0] = load_req.a_elem0[WORD_BITS-1:0];
    assign in_a[1] = load_req.a_elem1[WORD_BITS-1:0];
    assign in_a[2] = load_req.a_elem2[WORD_BITS-1:0];
    assign in_a[3] = load_req.a_elem3[WORD_BITS-1:0];
    assign in_b[0] = load_req.b_elem0[WORD_BITS-1:0];
    assign in_b[1] = load_req.b_elem1[WORD_BITS-1:0];
    assign in_b[2] = load_req.b_elem2[WORD_BITS-1:0];
    assign in_b[3] = load_req.b_elem3[WORD_BITS-1:0];

    // stores: rows never written since reset read as zero
    always_ff @(posedge clk)
    begin
        if (cmd.store_wr)
        begin
            for (int c = 0; c < DIM; c++)
            begin
                a_store_reg[load_req.row_index][c] <= in_a[c];
                b_store_reg[load_req.row_index][c] <= in_b[c];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (cmd.store_wr)
        begin
            row_valid_reg[load_req.row_index] <= 1'b1;
        end
    end

    // A[i][k] shared by all lanes, B[k][j] per lane
    always_comb
    begin
        a_sel = row_valid_reg[cmd.row] ? a_store_reg[cmd.row][cmd.step] : '0;
        for (int j = 0; j < DIM; j++)
        begin
            b_sel[j] = row_valid_reg[cmd.step] ? b_store_reg[cmd.step][j] : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            for (int j = 0; j < DIM; j++)
            begin
                prod_reg[j] <= a_sel * b_sel[j];
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < DIM; j++)
        begin
            acc_next[j] = (p_first_reg ? ACC_W'(0) : acc_reg[j]) + ACC_W'(prod_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_valid_reg)
        begin
            for (int j = 0; j < DIM; j++)
            begin
                acc_reg[j] <= acc_next[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg  <= 1'b0;
            p_first_reg  <= 1'b0;
            p_last_reg   <= 1'b0;
            acc_done_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= cmd.issue;
            p_first_reg <= cmd.first;
            p_last_reg  <= cmd.last;
            if (cmd.load_out)
            begin
                acc_done_reg <= 1'b0;
            end
            else if (p_valid_reg && p_last_reg)
            begin
                acc_done_reg <= 1'b1;
            end
        end
    end

    // floor shift, then clamp to the signed word range
    always_comb
    begin
        logic signed [ACC_W-1:0] shifted;
        word_t                   clamped;
        for (int j = 0; j < DIM; j++)
        begin
            shifted = acc_reg[j] >>> FRAC_BITS;
            if (shifted > SAT_MAX)
            begin
                clamped = SAT_MAX[WORD_BITS-1:0];
            end
            else if (shifted < SAT_MIN)
            begin
                clamped = SAT_MIN[WORD_BITS-1:0];
            end
            else
            begin
                clamped = shifted[WORD_BITS-1:0];
            end
            sat_elem[j] = ELEM_W'(clamped);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg.out_row    <= cmd.row;
            out_reg.prod_elem0 <= sat_elem[0];
            out_reg.prod_elem1 <= sat_elem[1];
            out_reg.prod_elem2 <= sat_elem[2];
            out_reg.prod_elem3 <= sat_elem[3];
            out_reg.last_row   <= (cmd.row == LAST_IDX);
        end
    end

    assign stat.acc_done = acc_done_reg;
    assign result_req    = out_reg;

endmodule

// File: rtl/core/mm4_ctrl.sv
// Controller of the 4x4 matrix multiply core: input handshake, row/step
// sequencing and result valid. Depends on mm4_pkg.
module mm4_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load_valid,
    output logic                   load_ready,
    input  logic [mm4_pkg::IDX_W-1:0] load_row,
    output logic                   result_valid,
    input  logic                   result_ready,
    input  mm4_pkg::mm4_status_t   stat,
    output mm4_pkg::mm4_cmd_t      cmd
);
    import mm4_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_FINISH
    } state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] row_reg;
    logic [IDX_W-1:0] step_reg;
    logic             out_valid_reg;
    logic             accept;
    logic             slot_free;

    assign load_ready = (state_reg == S_IDLE);
    assign accept     = load_valid && load_ready;
    assign slot_free  = !out_valid_reg || result_ready;

    always_comb
    begin
        cmd.store_wr = accept;
        cmd.issue    = (state_reg == S_ISSUE);
        cmd.row      = row_reg;
        cmd.step     = step_reg;
        cmd.first    = (step_reg == '0);
        cmd.last     = (step_reg == LAST_IDX);
        cmd.load_out = (state_reg == S_FINISH) && stat.acc_done && slot_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && (load_row == LAST_IDX))
                    begin
                        state_reg <= S_ISSUE;
                        row_reg   <= '0;
                        step_reg  <= '0;
                    end
                end
                S_ISSUE:
                begin
                    step_reg <= step_reg + IDX_W'(1);
                    if (step_reg == LAST_IDX)
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (cmd.load_out)
                    begin
                        if (row_reg == LAST_IDX)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_ISSUE;
                            row_reg   <= row_reg + IDX_W'(1);
                            step_reg  <= '0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid = out_valid_reg;

endmodule

// File: bench/tb_matrix_multiply_4x4_core.sv
// Self-checking bench for matrix_multiply_4x4_core: row loads in, product rows out.
// Depends on mm4_pkg and the core RTL; carries its own fixed-point product predictor.
// Directed cases; random stalls in two phases, none in a third; then a drain check.

module tb_matrix_multiply_4x4_core;

    timeunit 1ns;
    timeprecision 1ps;

    import mm4_pkg::*;

    localparam int FRAC_BITS    = 16;
    localparam int WORD_BITS    = 32;
    localparam int RAND_ITEMS   = 160;     // minimum random load requests per phase
    localparam int DRAIN_CYCLES = 40;      // settle time after the last expected row, to catch extra rows
    localparam int MAX_PRINTS   = 40;

    localparam logic [31:0] Q_ONE  = 32'h0001_0000;
    localparam logic [31:0] Q_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN  = 32'h8000_0000;
    localparam logic [31:0] Q_NEG1 = 32'hFFFF_FFFF;   // one LSB below zero

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        load_valid   = 1'b0;
    logic        load_ready;
    load_req_t   load_req     = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    result_req_t result_req;

    // Bench-side copy of both matrices, row-major, as the block holds them.
    logic [31:0] a_mat [16];
    logic [31:0] b_mat [16];

    load_req_t   load_queue [$];     // requests not yet offered
    result_req_t product_rows [$];   // predicted product rows, oldest first

    int pushed_cnt    = 0;
    int accepted_cnt  = 0;
    int error_count   = 0;
    int send_idle_pct = 18;
    int recv_idle_pct = 56;

    matrix_multiply_4x4_core #(
        .FRAC_BITS (FRAC_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .load_valid   (load_valid),
        .load_ready   (load_ready),
        .load_req     (load_req),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_req   (result_req)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run limit: far above the slowest legal run, receiver stalls included.
    initial
    begin
        #2_400_000;
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Error reporting: one line per problem, printing capped, all counted.
    // ------------------------------------------------------------------
    task automatic flag_error(input string msg);
        if (error_count < MAX_PRINTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Fixed-point predictor
    // ------------------------------------------------------------------

    // Keep the low WORD_BITS bits of a stored word, read as two's complement.
    function automatic longint word_value(input logic [31:0] w);
        longint v;
        v = longint'($signed(w));
        v = (v <<< (64 - WORD_BITS)) >>> (64 - WORD_BITS);
        return v;
    endfunction

    // C[i][j]: exact sum of four products, floor shift by FRAC_BITS, then
    // clamp to the signed WORD_BITS range. 66 bits hold the worst case
    // (four products of min * min add up to 2^64).
    function automatic logic [31:0] product_elem(input int i, input int j);
        logic signed [65:0] acc;
        logic signed [65:0] hi_lim;
        logic signed [65:0] lo_lim;
        longint             p;
        acc    = '0;
        hi_lim = (66'sd1 <<< (WORD_BITS - 1)) - 66'sd1;
        lo_lim = -(66'sd1 <<< (WORD_BITS - 1));
        for (int k = 0; k < DIM; k++)
        begin
            p   = word_value(a_mat[i*DIM + k]) * word_value(b_mat[k*DIM + j]);
            acc = acc + p;
        end
        acc = acc >>> FRAC_BITS;
        if (acc > hi_lim)
            acc = hi_lim;
        else if (acc < lo_lim)
            acc = lo_lim;
        // value fits WORD_BITS signed, so its low 32 bits are the sign-extended form
        return acc[31:0];
    endfunction

    // An accepted load request: store the row; row 3 also yields all of C.
    task automatic absorb_row(input load_req_t req);
        int          r;
        result_req_t pr;
        r = int'(req.row_index);
        a_mat[r*DIM + 0] = req.a_elem0;
        a_mat[r*DIM + 1] = req.a_elem1;
        a_mat[r*DIM + 2] = req.a_elem2;
        a_mat[r*DIM + 3] = req.a_elem3;
        b_mat[r*DIM + 0] = req.b_elem0;
        b_mat[r*DIM + 1] = req.b_elem1;
        b_mat[r*DIM + 2] = req.b_elem2;
        b_mat[r*DIM + 3] = req.b_elem3;
        if (req.row_index == LAST_IDX)
        begin
            for (int i = 0; i < DIM; i++)
            begin
                pr.out_row    = IDX_W'(i);
                pr.prod_elem0 = product_elem(i, 0);
                pr.prod_elem1 = product_elem(i, 1);
                pr.prod_elem2 = product_elem(i, 2);
                pr.prod_elem3 = product_elem(i, 3);
                pr.last_row   = (i == DIM - 1);
                product_rows.push_back(pr);
            end
        end
    endtask

    // Compare one accepted result request against the oldest prediction.
    task automatic check_row(input result_req_t got);
        result_req_t want;
        if (product_rows.size() == 0)
        begin
            flag_error($sformatf("unexpected result row %0d", got.out_row));
        end
        else
        begin
            want = product_rows.pop_front();
            if (got.out_row !== want.out_row)
                flag_error($sformatf("out_row got %0d want %0d", got.out_row, want.out_row));
            if (got.prod_elem0 !== want.prod_elem0)
                flag_error($sformatf("row %0d prod_elem0 got %h want %h",
                                     want.out_row, got.prod_elem0, want.prod_elem0));
            if (got.prod_elem1 !== want.prod_elem1)
                flag_error($sformatf("row %0d prod_elem1 got %h want %h",
                                     want.out_row, got.prod_elem1, want.prod_elem1));
            if (got.prod_elem2 !== want.prod_elem2)
                flag_error($sformatf("row %0d prod_elem2 got %h want %h",
                                     want.out_row, got.prod_elem2, want.prod_elem2));
            if (got.prod_elem3 !== want.prod_elem3)
                flag_error($sformatf("row %0d prod_elem3 got %h want %h",
                                     want.out_row, got.prod_elem3, want.prod_elem3));
            if (got.last_row !== want.last_row)
                flag_error($sformatf("row %0d last_row got %b want %b",
                                     want.out_row, got.last_row, want.last_row));
        end
    endtask

    // ------------------------------------------------------------------
    // Load-side driver: offers queued requests, holds them until taken.
    // Predictor runs on the edge where the request is accepted.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_valid <= 1'b0;
            for (int n = 0; n < DIM*DIM; n++)
            begin
                a_mat[n] = '0;
                b_mat[n] = '0;
            end
        end
        else
        begin
            if (load_valid && load_ready)
            begin
                absorb_row(load_req);
                accepted_cnt++;
            end
            // free to change the payload only when nothing is held
            if (!load_valid || load_ready)
            begin
                if (load_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    load_req   <= load_queue.pop_front();
                    load_valid <= 1'b1;
                end
                else
                begin
                    load_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result-side monitor: random back-pressure, check on each transfer.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
                check_row(result_req);
            result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic load_req_t make_load(input logic [1:0] row,
                                            input logic [31:0] a0, input logic [31:0] a1,
                                            input logic [31:0] a2, input logic [31:0] a3,
                                            input logic [31:0] b0, input logic [31:0] b1,
                                            input logic [31:0] b2, input logic [31:0] b3);
        load_req_t req;
        req.row_index = row;
        req.a_elem0 = a0;
        req.a_elem1 = a1;
        req.a_elem2 = a2;
        req.a_elem3 = a3;
        req.b_elem0 = b0;
        req.b_elem1 = b1;
        req.b_elem2 = b2;
        req.b_elem3 = b3;
        return req;
    endfunction

    task automatic queue_load(input load_req_t req);
        load_queue.push_back(req);
        pushed_cnt++;
    endtask

    // Mix of magnitudes: full-range words saturate often, small Q16.16
    // values keep sums in range and exercise rounding, plus the corners.
    function automatic logic [31:0] rand_elem();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2:    v = $urandom;
            3, 4, 5:    v = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            6, 7:       v = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
            8:          v = $urandom_range(0, 64) - 32;
            default:
            begin
                case ($urandom_range(0, 4))
                    0:       v = Q_MAX;
                    1:       v = Q_MIN;
                    2:       v = Q_NEG1;
                    3:       v = Q_ONE;
                    default: v = '0;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic load_req_t rand_load(input logic [1:0] row);
        return make_load(row, rand_elem(), rand_elem(), rand_elem(), rand_elem(),
                         rand_elem(), rand_elem(), rand_elem(), rand_elem());
    endfunction

    // Mostly full matrix loads (rows 0..2 shuffled, some skipped so stale
    // rows get reused, then row 3); the rest stray rows and unfinished sets.
    task automatic queue_random(input int count);
        int start;
        int order [3];
        int pick;
        int tmp;
        start = pushed_cnt;
        while (pushed_cnt - start < count)
        begin
            case ($urandom_range(0, 9))
                8:
                begin
                    queue_load(rand_load(2'($urandom_range(0, 3))));
                end
                9:
                begin
                    repeat ($urandom_range(1, 3))
                        queue_load(rand_load(2'($urandom_range(0, 2))));
                end
                default:
                begin
                    order[0] = 0;
                    order[1] = 1;
                    order[2] = 2;
                    for (int n = 2; n > 0; n--)
                    begin
                        pick        = $urandom_range(0, n);
                        tmp         = order[n];
                        order[n]    = order[pick];
                        order[pick] = tmp;
                    end
                    for (int n = 0; n < 3; n++)
                        if ($urandom_range(0, 9) != 0)
                            queue_load(rand_load(2'(order[n])));
                    queue_load(rand_load(LAST_IDX));
                end
            endcase
        end
    endtask

    // Wait, on handshakes only, until every queued request is taken.
    task automatic wait_accepted();
        while (accepted_cnt != pushed_cnt)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed part ---
        // row 3 straight after reset: rows 0..2 of both stores still zero
        queue_load(make_load(2'd3, Q_ONE, Q_MAX, Q_MIN, Q_NEG1,
                             Q_ONE, Q_NEG1, Q_MAX, Q_MIN));
        // identity times a random B gives B back
        for (int r = 0; r < DIM; r++)
            queue_load(make_load(2'(r),
                                 (r == 0) ? Q_ONE : '0, (r == 1) ? Q_ONE : '0,
                                 (r == 2) ? Q_ONE : '0, (r == 3) ? Q_ONE : '0,
                                 rand_elem(), rand_elem(), rand_elem(), rand_elem()));
        // largest positive everywhere: positive clamp
        for (int r = 0; r < DIM; r++)
            queue_load(make_load(2'(r), Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                 Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        // min times max: negative clamp
        for (int r = 0; r < DIM; r++)
            queue_load(make_load(2'(r), Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                 Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        // min times min: sum reaches 2^64, past any 64-bit accumulator
        for (int r = 0; r < DIM; r++)
            queue_load(make_load(2'(r), Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                 Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        // tiny negative sums floor to -1, tiny positive ones to 0
        for (int r = 0; r < DIM; r++)
            queue_load(make_load(2'(r), Q_NEG1, 32'd1, Q_NEG1, 32'd3,
                                 32'd1, 32'd1, Q_NEG1, 32'd1));
        // out-of-order rows, row 1 left stale from the previous product
        queue_load(rand_load(2'd2));
        queue_load(rand_load(2'd0));
        queue_load(rand_load(LAST_IDX));

        // phase 1: sender idles lightly, receiver stalls often
        queue_random(RAND_ITEMS);
        wait_accepted();

        // phase 2: roles swapped
        send_idle_pct = 56;
        recv_idle_pct = 18;
        queue_random(RAND_ITEMS);
        wait_accepted();

        // phase 3: full throughput both ways
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(RAND_ITEMS);
        wait_accepted();

        while (product_rows.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (product_rows.size() != 0)
            flag_error($sformatf("%0d product rows never arrived", product_rows.size()));

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
